// File: rtl/core/abnl_pkg.sv
// Shared types and constants for the archive block name lister.
package abnl_pkg;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = RQ_AW + 1;

    localparam logic KIND_NAME  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_archive;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] value;
        logic [15:0] file_number;
        logic        name_last;
    } out_item_t;

    // Results produced by one request: zero, one or two items
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_t;

endpackage

// File: rtl/core/archive_block_name_lister.sv
// Top level: input register, block header walker and result queue.
//
//  channel | signals                       | payload
//  --------+-------------------------------+-----------------------------------
//  input   | in_valid / in_ready           | in_data  (data_byte, end_of_archive)
//  output  | out_valid / out_ready         | out_data (kind, value, file_number,
//          |                               |           name_last)
//
// One byte per cycle while the queue has room: a request is registered, then
// processed by the walker while the next byte is taken. A byte yields zero,
// one or two results into a four-entry queue; the walker advances only while
// the queue has two free slots, so a stalled output backs up into in_ready.
// Reset puts the walker in its signature skip and empties the queue.
module archive_block_name_lister
    import abnl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic     s1_valid_reg, s1_valid_next;
    in_item_t s1_data_reg;
    logic     room;
    logic     proc;
    res_t     res;

    assign proc     = s1_valid_reg && room;
    assign in_ready = !s1_valid_reg || room;

    always_comb
    begin
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (proc)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_data_reg <= in_data;
    end

    abnl_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (proc),
        .item       (s1_data_reg),
        .res        (res)
    );

    abnl_rfifo u_rfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: rtl/core/abnl_parse.sv
// Block header walker: parser state and per-byte next-state and result logic.
module abnl_parse
    import abnl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  in_item_t item,
    output res_t     res
);

    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_FHDR = 3'd2;
    localparam logic [2:0] PH_NAME = 3'd3;
    localparam logic [2:0] PH_SKIP = 3'd4;

    localparam logic [7:0]  FILE_BLOCK_TYPE = 8'h74;
    localparam logic [15:0] SIG_LEN         = 16'd7;
    localparam logic [15:0] BLK_HDR_LEN     = 16'd7;
    localparam logic [15:0] FILE_HDR_LEN    = 16'd25;
    localparam logic [32:0] FIXED_USED      = 33'd32;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] field_position_reg, field_position_next;
    logic [7:0]  block_type_reg, block_type_next;
    logic [15:0] block_header_size_reg, block_header_size_next;
    logic [31:0] packed_size_reg, packed_size_next;
    logic [15:0] name_length_reg, name_length_next;
    logic [32:0] skip_remaining_reg, skip_remaining_next;
    logic [15:0] file_count_reg, file_count_next;

    logic [15:0] fp_inc;
    logic [16:0] fp_inc_wide;
    logic [32:0] used;
    logic [32:0] skip_dec;
    logic        name_end;
    logic        emit_name;
    out_item_t   name_item;
    out_item_t   count_item;

    always_comb
    begin
        phase_next             = phase_reg;
        field_position_next    = field_position_reg;
        block_type_next        = block_type_reg;
        block_header_size_next = block_header_size_reg;
        packed_size_next       = packed_size_reg;
        name_length_next       = name_length_reg;
        skip_remaining_next    = skip_remaining_reg;
        file_count_next        = file_count_reg;

        fp_inc      = field_position_reg + 16'd1;
        fp_inc_wide = {1'b0, field_position_reg} + 17'd1;
        used        = FIXED_USED + {17'd0, name_length_reg};
        skip_dec    = skip_remaining_reg - 33'd1;
        name_end    = (fp_inc_wide >= {1'b0, name_length_reg});
        emit_name   = 1'b0;

        unique case (phase_reg)
            PH_SIG:
            begin
                field_position_next = fp_inc;
                if (fp_inc >= SIG_LEN)
                begin
                    field_position_next = '0;
                    phase_next          = PH_HDR;
                end
            end
            PH_FHDR:
            begin
                if (field_position_reg < 16'd4)
                    packed_size_next[8*field_position_reg[1:0] +: 8] = item.data_byte;
                else if (field_position_reg == 16'd19)
                    name_length_next[7:0] = item.data_byte;
                else if (field_position_reg == 16'd20)
                    name_length_next[15:8] = item.data_byte;
                else if (field_position_reg == 16'd21)
                    // sizes complete: stage the trailing skip in two steps
                    skip_remaining_next = {17'd0, block_header_size_reg}
                                        + {1'b0, packed_size_reg};
                else if (field_position_reg == 16'd22)
                    skip_remaining_next = (skip_remaining_reg > used) ?
                                          (skip_remaining_reg - used) : '0;
                field_position_next = fp_inc;
                if (fp_inc >= FILE_HDR_LEN)
                begin
                    field_position_next = '0;
                    if (name_length_reg != 16'd0)
                        phase_next = PH_NAME;
                    else
                        phase_next = (skip_remaining_reg != '0) ? PH_SKIP : PH_HDR;
                end
            end
            PH_NAME:
            begin
                emit_name           = 1'b1;
                field_position_next = fp_inc;
                if (name_end)
                begin
                    field_position_next = '0;
                    phase_next = (skip_remaining_reg != '0) ? PH_SKIP : PH_HDR;
                end
            end
            PH_SKIP:
            begin
                if (skip_remaining_reg != '0)
                    skip_remaining_next = skip_dec;
                if (skip_remaining_reg == '0 || skip_dec == '0)
                begin
                    field_position_next = '0;
                    phase_next          = PH_HDR;
                end
            end
            default:
            begin
                phase_next = PH_HDR;
                if (field_position_reg == 16'd2)
                    block_type_next = item.data_byte;
                else if (field_position_reg == 16'd5)
                    block_header_size_next[7:0] = item.data_byte;
                else if (field_position_reg == 16'd6)
                    block_header_size_next[15:8] = item.data_byte;
                field_position_next = fp_inc;
                if (fp_inc >= BLK_HDR_LEN)
                begin
                    field_position_next = '0;
                    if (block_type_next == FILE_BLOCK_TYPE)
                    begin
                        if (file_count_reg != 16'hFFFF)
                            file_count_next = file_count_reg + 16'd1;
                        packed_size_next = '0;
                        name_length_next = '0;
                        phase_next       = PH_FHDR;
                    end
                    else if (block_header_size_next > BLK_HDR_LEN)
                    begin
                        skip_remaining_next = {17'd0, block_header_size_next - BLK_HDR_LEN};
                        phase_next          = PH_SKIP;
                    end
                    else
                    begin
                        skip_remaining_next = '0;
                        phase_next          = PH_HDR;
                    end
                end
            end
        endcase

        name_item.kind        = KIND_NAME;
        name_item.value       = {8'd0, item.data_byte};
        name_item.file_number = file_count_reg;
        name_item.name_last   = name_end;

        count_item.kind        = KIND_COUNT;
        count_item.value       = file_count_next;
        count_item.file_number = '0;
        count_item.name_last   = 1'b1;

        res.count  = 2'd0;
        res.first  = count_item;
        res.second = count_item;
        if (item_valid)
        begin
            if (emit_name)
            begin
                res.first = name_item;
                res.count = item.end_of_archive ? 2'd2 : 2'd1;
            end
            else
            begin
                res.count = item.end_of_archive ? 2'd1 : 2'd0;
            end
        end

        // archive end: everything returns to the reset state
        if (item.end_of_archive)
        begin
            phase_next             = PH_SIG;
            field_position_next    = '0;
            block_type_next        = '0;
            block_header_size_next = '0;
            packed_size_next       = '0;
            name_length_next       = '0;
            skip_remaining_next    = '0;
            file_count_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_SIG;
            field_position_reg    <= '0;
            block_type_reg        <= '0;
            block_header_size_reg <= '0;
            packed_size_reg       <= '0;
            name_length_reg       <= '0;
            skip_remaining_reg    <= '0;
            file_count_reg        <= '0;
        end
        else if (item_valid)
        begin
            phase_reg             <= phase_next;
            field_position_reg    <= field_position_next;
            block_type_reg        <= block_type_next;
            block_header_size_reg <= block_header_size_next;
            packed_size_reg       <= packed_size_next;
            name_length_reg       <= name_length_next;
            skip_remaining_reg    <= skip_remaining_next;
            file_count_reg        <= file_count_next;
        end
    end

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SKIP |-> skip_remaining_reg != '0)
        else $error("skip phase with nothing left to skip");

    a_name_inside: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_NAME |-> field_position_reg < name_length_reg)
        else $error("name position beyond name length");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item.end_of_archive |=> phase_reg == PH_SIG && file_count_reg == '0)
        else $error("archive end did not restart the walker");

endmodule

// File: rtl/core/abnl_rfifo.sv
// Result queue: takes up to two results per cycle, delivers one per output handshake.
module abnl_rfifo
    import abnl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_t      push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    out_item_t        mem [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_CW-1:0] count_reg, count_next;
    logic [RQ_AW-1:0] wr_ptr_plus1;
    logic             pop;

    assign room         = (count_reg <= RQ_CW'(RQ_DEPTH - 2));
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + RQ_AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_AW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + RQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + RQ_CW'(push.count) - RQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: dv/tb.sv
// Testbench for archive_block_name_lister: byte-stream stimulus, walker predictor, result check.
`timescale 1ns / 1ps

module tb;
    import abnl_pkg::*;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          RANDOM_BYTES   = 500;
    localparam int          SIG_BYTES      = 7;
    localparam int          BLK_HDR_BYTES  = 7;
    localparam int          FILE_HDR_BYTES = 25;
    localparam logic [7:0]  FILE_BLOCK     = 8'h74;
    localparam logic [55:0] ARC_SIG        = 56'h00_07_21_52_61_72_1A;

    typedef enum logic [2:0] {
        WALK_SIG  = 3'd0,
        WALK_HDR  = 3'd1,
        WALK_FHDR = 3'd2,
        WALK_NAME = 3'd3,
        WALK_SKIP = 3'd4
    } walk_phase_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    archive_block_name_lister dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Walker state mirrored from the byte stream
    walk_phase_t w_phase;
    logic [15:0] w_pos;
    logic [7:0]  w_type;
    logic [15:0] w_hdr_size;
    logic [31:0] w_packed;
    logic [15:0] w_name_len;
    logic [32:0] w_skip;
    logic [15:0] w_files;

    out_item_t   listing_due[$];
    logic [7:0]  arc_bytes[$];
    int          mismatches;
    int          bytes_sent;
    int          cycle_count;
    bit          tx_gaps_on;
    bit          rx_gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic walker_reset();
        w_phase    = WALK_SIG;
        w_pos      = '0;
        w_type     = '0;
        w_hdr_size = '0;
        w_packed   = '0;
        w_name_len = '0;
        w_skip     = '0;
        w_files    = '0;
    endtask

    task automatic enter_skip(input longint amount);
        w_skip  = amount[32:0];
        w_pos   = '0;
        w_phase = (amount != 0) ? WALK_SKIP : WALK_HDR;
    endtask

    // Remainder of a file block after its name; never negative
    task automatic finish_file();
        longint total;
        longint used;
        total = longint'(w_hdr_size) + longint'(w_packed);
        used  = longint'(BLK_HDR_BYTES + FILE_HDR_BYTES) + longint'(w_name_len);
        enter_skip(total > used ? total - used : 0);
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic eoa);
        out_item_t r;
        case (w_phase)
            WALK_SIG:
            begin
                w_pos++;
                if (w_pos >= SIG_BYTES)
                begin
                    w_pos   = '0;
                    w_phase = WALK_HDR;
                end
            end
            WALK_FHDR:
            begin
                if (w_pos < 4)
                    w_packed = w_packed | (32'(b) << (8 * w_pos));
                else if (w_pos == 19)
                    w_name_len[7:0] = b;
                else if (w_pos == 20)
                    w_name_len[15:8] = b;
                w_pos++;
                if (w_pos >= FILE_HDR_BYTES)
                begin
                    w_pos = '0;
                    if (w_name_len != 0)
                        w_phase = WALK_NAME;
                    else
                        finish_file();
                end
            end
            WALK_NAME:
            begin
                r.kind        = KIND_NAME;
                r.value       = 16'(b);
                r.file_number = w_files;
                r.name_last   = (32'(w_pos) + 1 >= 32'(w_name_len));
                listing_due.push_back(r);
                w_pos++;
                if (w_pos >= w_name_len)
                    finish_file();
            end
            WALK_SKIP:
            begin
                if (w_skip != 0)
                    w_skip--;
                if (w_skip == 0)
                begin
                    w_pos   = '0;
                    w_phase = WALK_HDR;
                end
            end
            default:
            begin
                w_phase = WALK_HDR;
                if (w_pos == 2)
                    w_type = b;
                else if (w_pos == 5)
                    w_hdr_size[7:0] = b;
                else if (w_pos == 6)
                    w_hdr_size[15:8] = b;
                w_pos++;
                if (w_pos >= BLK_HDR_BYTES)
                begin
                    w_pos = '0;
                    if (w_type == FILE_BLOCK)
                    begin
                        // counted as soon as the block header is in
                        if (w_files != 16'hFFFF)
                            w_files++;
                        w_packed   = '0;
                        w_name_len = '0;
                        w_phase    = WALK_FHDR;
                    end
                    else
                        enter_skip(w_hdr_size > BLK_HDR_BYTES ?
                                   longint'(w_hdr_size) - BLK_HDR_BYTES : 0);
                end
            end
        endcase
        if (eoa)
        begin
            r.kind        = KIND_COUNT;
            r.value       = w_files;
            r.file_number = '0;
            r.name_last   = 1'b1;
            listing_due.push_back(r);
            walker_reset();
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (listing_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind=%0d value=%0h",
                                      got.kind, got.value));
            return;
        end
        want = listing_due.pop_front();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0b, want %0b", got.kind, want.kind));
        if (got.value !== want.value)
            report_mismatch($sformatf("value %0h, want %0h", got.value, want.value));
        if (got.file_number !== want.file_number)
            report_mismatch($sformatf("file_number %0d, want %0d",
                                      got.file_number, want.file_number));
        if (got.name_last !== want.name_last)
            report_mismatch($sformatf("name_last %0b, want %0b",
                                      got.name_last, want.name_last));
    endtask

    // Handshake decided at the falling edge, taken at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_data);
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_gaps_on ? $urandom_range(0, 7) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            @(posedge clk);
        end
    end

    // Called at a rising edge; returns at the edge that takes the request
    task automatic send_byte(input logic [7:0] b, input logic eoa);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_archive: eoa};
        do @(negedge clk); while (!in_ready);
        walk_byte(b, eoa);
        bytes_sent++;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (listing_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void put_le16(input logic [15:0] v);
        arc_bytes.push_back(v[7:0]);
        arc_bytes.push_back(v[15:8]);
    endfunction

    function automatic void add_signature(input bit genuine);
        for (int i = 0; i < SIG_BYTES; i++)
            arc_bytes.push_back(genuine ? ARC_SIG[55 - 8 * i -: 8] : rand_byte());
    endfunction

    function automatic void add_other_block(input logic [15:0] hsize);
        logic [7:0] t;
        t = rand_byte();
        if (t == FILE_BLOCK)
            t = t ^ 8'h01;
        put_le16({rand_byte(), rand_byte()});
        arc_bytes.push_back(t);
        put_le16({rand_byte(), rand_byte()});
        put_le16(hsize);
        for (int i = BLK_HDR_BYTES; i < int'(hsize); i++)
            arc_bytes.push_back(rand_byte());
    endfunction

    // fill < 0 gives random name bytes
    function automatic void add_file_block(input logic [15:0] hsize, input logic [31:0] psize,
                                           input logic [15:0] nlen, input int fill);
        longint rest;
        put_le16({rand_byte(), rand_byte()});
        arc_bytes.push_back(FILE_BLOCK);
        put_le16({rand_byte(), rand_byte()});
        put_le16(hsize);
        for (int i = 0; i < FILE_HDR_BYTES; i++)
        begin
            if (i < 4)
                arc_bytes.push_back(psize[8 * i +: 8]);
            else if (i == 19)
                arc_bytes.push_back(nlen[7:0]);
            else if (i == 20)
                arc_bytes.push_back(nlen[15:8]);
            else
                arc_bytes.push_back(rand_byte());
        end
        for (int i = 0; i < int'(nlen); i++)
            arc_bytes.push_back(fill < 0 ? rand_byte() : 8'(fill));
        rest = longint'(hsize) + longint'(psize) - 32 - longint'(nlen);
        for (longint i = 0; i < rest; i++)
            arc_bytes.push_back(rand_byte());
    endfunction

    // cut > 0 ends the archive early at that byte
    task automatic send_archive(input int cut);
        int n;
        n = (cut > 0 && cut < arc_bytes.size()) ? cut : arc_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(arc_bytes[i], i == n - 1);
        arc_bytes.delete();
    endtask

    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++)
            send_byte(rand_byte(), i == len - 1);
    endtask

    task automatic test_signature_end();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
    endtask

    task automatic test_short_block_header();
        add_signature(1'b0);
        add_other_block(16'd0);
        add_other_block(16'd7);
        add_other_block(16'd3);
        add_other_block(16'd8);
        send_archive(0);
    endtask

    task automatic test_file_names();
        add_signature(1'b1);
        add_file_block(16'd33, 32'd0, 16'd1, 8'hFF);
        add_file_block(16'd32, 32'd0, 16'd0, -1);    // empty name, still counted
        add_file_block(16'd0, 32'd2, 16'd2, 8'h00);  // short block, skip clamps
        add_file_block(16'd40, 32'd3, 16'd2, 8'h80);
        send_archive(0);
    endtask

    task automatic test_end_on_name();
        add_signature(1'b1);
        add_file_block(16'd35, 32'd0, 16'd3, -1);
        send_archive(SIG_BYTES + BLK_HDR_BYTES + FILE_HDR_BYTES + 2);
    endtask

    task automatic test_end_in_file_header();
        add_signature(1'b1);
        add_file_block(16'd36, 32'd1, 16'd4, -1);
        send_archive(SIG_BYTES + BLK_HDR_BYTES + 5);
    endtask

    task automatic test_random_archives();
        int  target;
        int  sel;
        int  nblocks;
        int  nlen;
        int  hsize;
        bit  paused;
        target = bytes_sent + RANDOM_BYTES;
        paused = 1'b0;
        while (bytes_sent < target)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 99);
            if (sel < 15)
                send_noise($urandom_range(1, 24));
            else
            begin
                add_signature(1'($urandom_range(0, 1)));
                nblocks = $urandom_range(0, 4);
                for (int k = 0; k < nblocks; k++)
                begin
                    if ($urandom_range(0, 9) < 6)
                    begin
                        nlen  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                        hsize = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                            : 32 + nlen + $urandom_range(0, 4);
                        add_file_block(16'(hsize), 32'($urandom_range(0, 6)), 16'(nlen), -1);
                    end
                    else
                        add_other_block(16'($urandom_range(0, 14)));
                end
                // broken archives end at a random byte
                send_archive(sel < 30 ? $urandom_range(1, arc_bytes.size()) : 0);
            end
            if (!paused && bytes_sent >= target - RANDOM_BYTES / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        mismatches  = 0;
        bytes_sent  = 0;
        cycle_count = 0;
        tx_gaps_on  = 1'b1;
        rx_gaps_on  = 1'b1;
        walker_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_signature_end();
        test_short_block_header();
        test_file_names();
        test_end_on_name();
        test_end_in_file_header();
        test_random_archives();

        wait_drained();
        repeat (16) @(posedge clk);
        while (listing_due.size() != 0)
        begin
            report_mismatch($sformatf("missing result value=%0h", listing_due[0].value));
            void'(listing_due.pop_front());
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
